FILE: design/kmes_pkg.sv
package kmes_pkg;

	// Default matrix geometry.
	localparam int ROWS_DEFAULT    = 5;
	localparam int COLUMNS_DEFAULT = 14;

	// Field widths of the stream items.
	localparam int ROW_W        = 3;
	localparam int LEVEL_W      = 14;
	localparam int KEY_NUMBER_W = 7;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 8;

	localparam logic [KEY_NUMBER_W-1:0] LAST_KEY_RESET = KEY_NUMBER_W'(60);

	// Event kinds.
	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	// Per-key debounce phase.
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_ONCE = 3'b010,
		PH_HELD = 3'b100
	} phase_t;

	// What one column lane reports to the merge stage.
	typedef struct packed {
		logic valid;
		logic kind;
	} lane_event_t;

	// Width of an internal key index: wide enough for every key of the
	// matrix and never narrower than the configured limit.
	function automatic int key_w(input int keys);
		return ($clog2(keys) > KEY_NUMBER_W) ? $clog2(keys) : KEY_NUMBER_W;
	endfunction

endpackage

FILE: design/kmes_lane.sv
module kmes_lane import kmes_pkg::*; #(
	parameter int COL   = 0,
	parameter int KEY_W = KEY_NUMBER_W
) (
	input  logic                    enable,
	input  logic                    level,
	input  logic [KEY_W-1:0]        base,
	input  logic [KEY_NUMBER_W-1:0] last_key,
	input  phase_t                  phase,
	output phase_t                  phase_next,
	output lane_event_t             ev
);

	logic [KEY_W-1:0] key;
	logic             scan;

	assign key  = base + KEY_W'(COL);
	assign scan = enable && (key <= KEY_W'(last_key));

	always_comb begin
		phase_next = phase;
		ev         = '0;
		if (scan) begin
			case (phase)
				PH_ONCE: begin
					if (level) begin
						phase_next = PH_HELD;
						ev.valid   = 1'b1;
						ev.kind    = EV_PRESS;
					end
				end
				PH_HELD: begin
					if (!level) begin
						phase_next = PH_IDLE;
						ev.valid   = 1'b1;
						ev.kind    = EV_RELEASE;
					end
				end
				default: begin
					// Idle, and any damaged code, behave as idle.
					if (level) begin
						phase_next = PH_ONCE;
					end
				end
			endcase
		end
	end

endmodule

FILE: design/kmes_merge.sv
module kmes_merge import kmes_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEFAULT,
	parameter int KEY_W   = KEY_NUMBER_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [COLUMNS-1:0]      ev_mask,
	input  logic [COLUMNS-1:0]      ev_kind,
	input  logic [KEY_W-1:0]        base,
	output logic                    ready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [KEY_NUMBER_W-1:0] key_number,
	output logic                    event_kind,
	output logic                    last_event
);

	localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	logic [COLUMNS-1:0]      pend_q;
	logic [COLUMNS-1:0]      kind_q;
	logic [KEY_W-1:0]        base_q;
	logic                    valid_q;
	logic [KEY_NUMBER_W-1:0] key_q;
	logic                    kind_out_q;
	logic                    last_q;

	logic [COLUMNS-1:0] low_oh;
	logic [COLUMNS-1:0] rest;
	logic [COLUMNS-1:0] pend_after;
	logic [IDX_W-1:0]   low_idx;
	logic               found;
	logic               load;
	logic               last_w;

	always_comb begin
		low_idx = '0;
		found   = 1'b0;
		for (int c = 0; c < COLUMNS; c++) begin
			if (pend_q[c] && !found) begin
				found   = 1'b1;
				low_idx = IDX_W'(c);
			end
		end
	end

	assign low_oh     = pend_q & (~pend_q + COLUMNS'(1));
	assign rest       = pend_q & ~low_oh;
	assign last_w     = (rest == '0);
	assign load       = (pend_q != '0) && (!valid_q || m_tready);
	assign pend_after = load ? rest : pend_q;
	assign ready      = (pend_after == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			pend_q <= take ? ev_mask : pend_after;
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= ev_kind;
			base_q <= base;
		end
		if (load) begin
			key_q      <= KEY_NUMBER_W'(base_q + KEY_W'(low_idx));
			kind_out_q <= kind_q[low_idx];
			last_q     <= last_w;
		end
	end

	assign m_tvalid   = valid_q;
	assign key_number = key_q;
	assign event_kind = kind_out_q;
	assign last_event = last_q;

	a_take_loads_mask: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> pend_q == $past(ev_mask))
		else $error("pending events do not match the row just taken");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(pend_q) > 1) |-> !ready)
		else $error("input taken while several events still wait");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		load && last_w && !take |=> pend_q == '0)
		else $error("events remain after the one flagged last");

endmodule

FILE: design/key_matrix_event_scanner.sv
// Key matrix event scanner. Each input item is one scanned row: row_number
// and the sampled column levels. Every key keeps a debounce phase (idle,
// pressed once, held); a key seen high again on a later scan becomes held
// and yields a press event, a held key seen low yields a release event and
// returns to idle. Keys whose index (row * COLUMNS + column) is above the
// last_key_index register, and rows at or beyond ROWS, are left alone.
// One lane per column updates its key in the cycle the row is accepted, so
// a following row always sees the updated phases. The events of a row then
// leave one per cycle while m_tready is high, lowest column first, through
// an output register, and the final event of the row carries tlast; a row
// with no events yields nothing. The single output register drains one
// event per cycle while m_tready is high, and the next row is accepted in
// the cycle the last event of the previous row moves into it, so rows
// without events stream at one per cycle. The phase store sits in
// flip-flops cleared by reset, so the block is ready right after reset.
// last_key_index may be written at any cycle; cfg_ready is always high.
module key_matrix_event_scanner import kmes_pkg::*; #(
	parameter int ROWS    = ROWS_DEFAULT,
	parameter int COLUMNS = COLUMNS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Row items.
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// [2:0] row_number, [16:3] column_levels, [23:17] zero.
	input  logic [IN_DATA_W-1:0]    s_tdata,
	// Event items.
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// [6:0] key_number, [7] zero.
	output logic [OUT_DATA_W-1:0]   m_tdata,
	// [0] event_kind: 0 press, 1 release.
	output logic                    m_tuser,
	output logic                    m_tlast,
	// last_key_index register write.
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [KEY_NUMBER_W-1:0] cfg_data
);

	// The row width must also hold the value ROWS itself for the range check.
	localparam int KeyW    = key_w(ROWS * COLUMNS);
	localparam int RowW    = ($clog2(ROWS + 1) > ROW_W) ? $clog2(ROWS + 1) : ROW_W;
	localparam int RowSelW = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [KEY_NUMBER_W-1:0] last_key_q;

	// Phase store, one entry per key, organized by row.
	phase_t phase_q [ROWS][COLUMNS];

	logic [ROW_W-1:0]   row_number;
	logic [LEVEL_W-1:0] column_levels;
	logic [RowW-1:0]    row_ext;
	logic [RowSelW-1:0] row_idx;
	logic               row_ok;
	logic               take;
	logic [KeyW-1:0]    base;
	logic [COLUMNS-1:0] level;
	logic [COLUMNS-1:0] ev_mask;
	logic [COLUMNS-1:0] ev_kind;
	logic [KEY_NUMBER_W-1:0] key_number;
	logic               merge_ready;

	phase_t      phase_rd  [COLUMNS];
	phase_t      phase_nxt [COLUMNS];
	lane_event_t lane_ev   [COLUMNS];

	assign row_number    = s_tdata[ROW_W-1:0];
	assign column_levels = s_tdata[ROW_W+LEVEL_W-1:ROW_W];

	assign row_ext = RowW'(row_number);
	assign row_idx = row_ext[RowSelW-1:0];
	assign row_ok  = (row_ext < RowW'(ROWS));
	assign base    = KeyW'(row_ext) * KeyW'(COLUMNS);

	assign s_tready = merge_ready;
	assign take     = s_tvalid && s_tready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_key_q <= LAST_KEY_RESET;
		end else if (cfg_valid) begin
			last_key_q <= cfg_data;
		end
	end

	// One lane per column; columns past the sampled width read low.
	for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
		if (c < LEVEL_W) begin : g_lvl
			assign level[c] = column_levels[c];
		end else begin : g_low
			assign level[c] = 1'b0;
		end

		assign phase_rd[c] = phase_q[row_idx][c];

		kmes_lane #(
			.COL   (c),
			.KEY_W (KeyW)
		) u_lane (
			.enable     (row_ok),
			.level      (level[c]),
			.base       (base),
			.last_key   (last_key_q),
			.phase      (phase_rd[c]),
			.phase_next (phase_nxt[c]),
			.ev         (lane_ev[c])
		);

		assign ev_mask[c] = lane_ev[c].valid;
		assign ev_kind[c] = lane_ev[c].kind;
	end

	// Phases are written back in the cycle the row is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLUMNS; c++) begin
					phase_q[r][c] <= PH_IDLE;
				end
			end
		end else if (take && row_ok) begin
			for (int c = 0; c < COLUMNS; c++) begin
				phase_q[row_idx][c] <= phase_nxt[c];
			end
		end
	end

	kmes_merge #(
		.COLUMNS (COLUMNS),
		.KEY_W   (KeyW)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.ev_mask    (ev_mask),
		.ev_kind    (ev_kind),
		.base       (base),
		.ready      (merge_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.key_number (key_number),
		.event_kind (m_tuser),
		.last_event (m_tlast)
	);

	assign m_tdata = OUT_DATA_W'(key_number);

endmodule

FILE: tb/key_matrix_event_scanner_test.sv
module key_matrix_event_scanner_test;
	import kmes_pkg::*;

	localparam int ROWS    = ROWS_DEFAULT;
	localparam int COLUMNS = COLUMNS_DEFAULT;
	localparam int KEYS    = ROWS * COLUMNS;

	// Cycles the block may still be busy after the last expected event has left.
	localparam int SETTLE_CYCLES = 8;

	// One key event as it leaves the block.
	typedef struct packed {
		logic [KEY_NUMBER_W-1:0] key;
		logic                    kind;
		logic                    last;
	} key_event_t;

	// One row of the directed plan. A row either writes last_key_index once the
	// block has drained, or sends one scanned row. typed_count is the number of
	// events that can be read straight off the rules, or -1 when only the
	// scan model decides; typed_key and typed_kind describe the first event.
	typedef struct packed {
		logic                    set_limit;
		logic [KEY_NUMBER_W-1:0] limit;
		logic [ROW_W-1:0]        row;
		logic [LEVEL_W-1:0]      levels;
		int                      typed_count;
		logic [KEY_NUMBER_W-1:0] typed_key;
		logic                    typed_kind;
	} plan_step_t;

	localparam int PLAN_LEN = 26;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	// [2:0] row_number, [16:3] column_levels, [23:17] zero.
	logic [IN_DATA_W-1:0]    s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	// [6:0] key_number, [7] zero.
	logic [OUT_DATA_W-1:0]   m_tdata;
	// [0] event_kind: 0 press, 1 release.
	logic                    m_tuser;
	logic                    m_tlast;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [KEY_NUMBER_W-1:0] cfg_data;

	// Scan model state: its own copy of every key phase and of the limit.
	phase_t                  key_phase_model [KEYS];
	logic [KEY_NUMBER_W-1:0] scan_limit;
	key_event_t              first_event;

	// Events predicted but not yet seen on the output, oldest first.
	key_event_t              pending_events [$];

	int                      mismatches;
	// When set, neither side inserts gaps or stalls.
	bit                      quiet_link;
	int                      stall_left;

	// The matrix as the random part imagines it: which keys a typist holds.
	logic [LEVEL_W-1:0]      row_pattern [ROWS];

	plan_step_t plan [0:PLAN_LEN-1] = '{
		// Fresh after reset: a low row does nothing.
		'{1'b0, 7'd0, 3'd0, 14'h0000, 0, 7'd0, EV_PRESS},
		// Full row 0: first scan arms every key, second scan presses them all.
		'{1'b0, 7'd0, 3'd0, 14'h3FFF, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd0, 14'h3FFF, 14, 7'd0, EV_PRESS},
		// Held keys seen high again stay quiet.
		'{1'b0, 7'd0, 3'd0, 14'h3FFF, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd0, 14'h0000, 14, 7'd0, EV_RELEASE},
		// Last row under the reset limit of 60: only keys 56 to 60 count.
		'{1'b0, 7'd0, 3'd4, 14'h3FFF, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd4, 14'h3FFF, 5, 7'd56, EV_PRESS},
		// Rows past the matrix are dropped.
		'{1'b0, 7'd0, 3'd5, 14'h3FFF, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd7, 14'h3FFF, 0, 7'd0, EV_PRESS},
		// A key seen high once and then low stays armed and reports nothing yet.
		'{1'b0, 7'd0, 3'd3, 14'h2001, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd3, 14'h0001, 1, 7'd42, EV_PRESS},
		// Release of column 0 leaves ahead of the press of column 13.
		'{1'b0, 7'd0, 3'd3, 14'h2000, 2, 7'd42, EV_RELEASE},
		'{1'b0, 7'd0, 3'd4, 14'h0000, 5, 7'd56, EV_RELEASE},
		'{1'b0, 7'd0, 3'd1, 14'h1555, -1, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd2, 14'h2AAA, -1, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd1, 14'h2AAA, -1, 7'd0, EV_PRESS},
		// Smallest limit: only key 0 is alive.
		'{1'b1, 7'd0, 3'd0, 14'h0000, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd0, 14'h3FFF, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd0, 14'h3FFF, 1, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd1, 14'h3FFF, 0, 7'd0, EV_PRESS},
		// Limit beyond the matrix: the whole last row is scanned.
		'{1'b1, 7'd127, 3'd0, 14'h0000, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd4, 14'h3FFF, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd4, 14'h3FFF, 14, 7'd56, EV_PRESS},
		// Limit at the very last key.
		'{1'b1, 7'd69, 3'd0, 14'h0000, 0, 7'd0, EV_PRESS},
		'{1'b0, 7'd0, 3'd4, 14'h0000, 14, 7'd56, EV_RELEASE},
		'{1'b0, 7'd0, 3'd0, 14'h0000, 1, 7'd0, EV_RELEASE}
	};

	key_matrix_event_scanner #(
		.ROWS(ROWS),
		.COLUMNS(COLUMNS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Hard limit on the whole run, far above the slowest legal run.
	initial begin
		#8000000;
		$display("key_matrix_event_scanner test failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 40) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
		mismatches++;
	endtask

	// Mostly no pause, sometimes a short one, now and then a long one.
	function automatic int pick_pause();
		int pick;
		pick = $urandom_range(0, 99);
		if (quiet_link || pick < 60) begin
			return 0;
		end
		if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Applies one accepted row to the key phases, queues the events it causes
	// and returns how many there are. The first one is kept in first_event.
	function automatic int scan_row(input logic [ROW_W-1:0] row,
			input logic [LEVEL_W-1:0] levels);
		int         key;
		int         count;
		bit         have_prev;
		key_event_t prev;
		key_event_t ev;
		count = 0;
		have_prev = 1'b0;
		prev = '0;
		if (row >= ROWS) begin
			return 0;
		end
		for (int col = 0; col < COLUMNS; col++) begin
			key = row * COLUMNS + col;
			if (key > scan_limit || key >= KEYS) begin
				break;
			end
			ev.key  = KEY_NUMBER_W'(key);
			ev.last = 1'b0;
			ev.kind = EV_PRESS;
			if (levels[col]) begin
				// A key high again on a later scan becomes held; anything
				// other than armed or held counts as idle.
				if (key_phase_model[key] == PH_ONCE) begin
					key_phase_model[key] = PH_HELD;
					ev.kind = EV_PRESS;
				end else begin
					if (key_phase_model[key] != PH_HELD) begin
						key_phase_model[key] = PH_ONCE;
					end
					continue;
				end
			end else if (key_phase_model[key] == PH_HELD) begin
				key_phase_model[key] = PH_IDLE;
				ev.kind = EV_RELEASE;
			end else begin
				continue;
			end
			// Hold each event back by one so that the final one can be flagged.
			if (have_prev) begin
				pending_events.push_back(prev);
			end else begin
				first_event = ev;
			end
			prev = ev;
			have_prev = 1'b1;
			count++;
		end
		if (have_prev) begin
			prev.last = 1'b1;
			if (count == 1) begin
				first_event = prev;
			end
			pending_events.push_back(prev);
		end
		return count;
	endfunction

	// Offers one row after a pause of the given number of cycles and waits for
	// the block to take it; the events it causes are queued at that edge.
	task automatic send_row(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] levels,
			input int pause, output int count);
		if (pause > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (pause - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_DATA_W - ROW_W - LEVEL_W){1'b0}}, levels, row};
		do begin
			@(posedge clk);
		end while (!s_tready);
		count = scan_row(row, levels);
	endtask

	// Stops offering rows and waits until every expected event has left and
	// the block has had time to finish rows that cause none.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The register is only written while the block is idle.
	task automatic write_limit(input logic [KEY_NUMBER_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		scan_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Event sink: ready most of the time, with stalls of random length.
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !quiet_link) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = 0;
				if ($urandom_range(0, 99) < 20) begin
					stall_left = pick_pause();
				end
			end
		end
	end

	// Every event taken by the sink is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("event for key %0d kind %0d with none expected",
					m_tdata[KEY_NUMBER_W-1:0], m_tuser));
			end else begin
				if (m_tdata[KEY_NUMBER_W-1:0] !== pending_events[0].key) begin
					report_mismatch($sformatf("key_number %0d, expected %0d",
						m_tdata[KEY_NUMBER_W-1:0], pending_events[0].key));
				end
				if (m_tuser !== pending_events[0].kind) begin
					report_mismatch($sformatf("event_kind %0d for key %0d, expected %0d",
						m_tuser, pending_events[0].key, pending_events[0].kind));
				end
				if (m_tlast !== pending_events[0].last) begin
					report_mismatch($sformatf("last_event %0d for key %0d, expected %0d",
						m_tlast, pending_events[0].key, pending_events[0].last));
				end
				void'(pending_events.pop_front());
			end
		end
	end

	initial begin
		int                      n;
		int                      sent;
		logic [KEY_NUMBER_W-1:0] limit;
		logic [LEVEL_W-1:0]      glitch;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		mismatches = 0;
		quiet_link = 1'b0;
		scan_limit = LAST_KEY_RESET;
		for (int k = 0; k < KEYS; k++) begin
			key_phase_model[k] = PH_IDLE;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. The first rows run on the reset value of the limit.
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].set_limit) begin
				write_limit(plan[i].limit);
			end else begin
				send_row(plan[i].row, plan[i].levels, pick_pause(), n);
				if (plan[i].typed_count >= 0) begin
					if (n != plan[i].typed_count) begin
						report_mismatch($sformatf("plan row %0d gives %0d events, table says %0d",
							i, n, plan[i].typed_count));
					end else if (n > 0 && (first_event.key != plan[i].typed_key ||
							first_event.kind != plan[i].typed_kind)) begin
						report_mismatch($sformatf("plan row %0d first event key %0d kind %0d",
							i, first_event.key, first_event.kind));
					end
				end
			end
		end

		// Random part: sweeps over the matrix while the held keys change slowly,
		// so keys walk through arming, pressing and releasing; the rest is noise
		// including rows past the matrix and one-scan glitches.
		for (int r = 0; r < ROWS; r++) begin
			row_pattern[r] = LEVEL_W'($urandom);
		end
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					limit = 7'd69;
				end
				1: begin
					limit = KEY_NUMBER_W'($urandom_range(1, 69));
				end
				2: begin
					limit = 7'd127;
				end
				default: begin
					limit = KEY_NUMBER_W'($urandom_range(30, 69));
				end
			endcase
			write_limit(limit);
			sent = 0;
			while (sent < 80) begin
				quiet_link = ($urandom_range(0, 7) == 0);
				if ($urandom_range(0, 99) < 15) begin
					send_row(ROW_W'($urandom_range(0, 7)), LEVEL_W'($urandom), pick_pause(), n);
					sent++;
				end else begin
					for (int r = 0; r < ROWS; r++) begin
						if ($urandom_range(0, 19) == 0) begin
							row_pattern[r] = LEVEL_W'($urandom);
						end else if ($urandom_range(0, 3) == 0) begin
							row_pattern[r] ^= LEVEL_W'(1 << $urandom_range(0, LEVEL_W - 1));
						end
						glitch = '0;
						if ($urandom_range(0, 9) == 0) begin
							glitch = LEVEL_W'(1 << $urandom_range(0, LEVEL_W - 1));
						end
						send_row(ROW_W'(r), row_pattern[r] ^ glitch, pick_pause(), n);
						sent++;
					end
				end
			end
		end
		quiet_link = 1'b0;

		drain();
		if (mismatches == 0) begin
			$display("key_matrix_event_scanner test passed");
		end else begin
			$display("key_matrix_event_scanner test failed");
		end
		$finish;
	end

endmodule
